@@ design/ted_pkg.sv @@
`timescale 1ns / 1ps
package ted_pkg;

	// Table geometry
	localparam int MAX_EDGES   = 1024;
	localparam int VERTEX_BITS = 16;
	localparam int IDX_W       = $clog2(MAX_EDGES);
	localparam int CNT_W       = IDX_W + 1;
	localparam int NEED_W      = 2;

	// Result field widths
	localparam int OUT_IDX_W = 10;
	localparam int FACE_W    = 16;
	localparam int MASK_W    = 3;

	// Edge positions within a face
	localparam int EDGE_AB = 0;
	localparam int EDGE_BC = 1;
	localparam int EDGE_CA = 2;
	localparam int NUM_EDGES = 3;

	typedef logic [VERTEX_BITS-1:0] vert_t;

	typedef struct packed {
		vert_t lo;
		vert_t hi;
	} pair_t;

	// What one lane found over the scan
	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] idx;
	} lane_t;

	// Combined decision for the face
	typedef struct packed {
		logic                           full;
		logic [NEED_W-1:0]              need;
		logic [NUM_EDGES-1:0]           mask;
		logic [NUM_EDGES-1:0][IDX_W-1:0] idx;
	} merge_t;

endpackage

@@ design/ted_face_if.sv @@
`timescale 1ns / 1ps
interface ted_face_if;
	import ted_pkg::*;

	logic  valid;
	logic  ready;
	vert_t vert_a;
	vert_t vert_b;
	vert_t vert_c;

	modport source (output valid, output vert_a, output vert_b, output vert_c, input ready);
	modport sink (input valid, input vert_a, input vert_b, input vert_c, output ready);

endinterface

@@ design/ted_res_if.sv @@
`timescale 1ns / 1ps
interface ted_res_if;
	import ted_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [OUT_IDX_W-1:0] edge_ab_index;
	logic [OUT_IDX_W-1:0] edge_bc_index;
	logic [OUT_IDX_W-1:0] edge_ca_index;
	logic [MASK_W-1:0]    new_edge_mask;
	logic [FACE_W-1:0]    face_number;
	logic                 table_full;

	modport source (output valid, output edge_ab_index, output edge_bc_index,
		output edge_ca_index, output new_edge_mask, output face_number,
		output table_full, input ready);
	modport sink (input valid, input edge_ab_index, input edge_bc_index,
		input edge_ca_index, input new_edge_mask, input face_number,
		input table_full, output ready);

endinterface

@@ design/ted_edge_lane.sv @@
`timescale 1ns / 1ps
module ted_edge_lane
	import ted_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clear,
	input  logic             en,
	input  logic [IDX_W-1:0] entry_idx,
	input  pair_t            entry,
	input  vert_t            x,
	input  vert_t            y,
	output lane_t            res
);

	logic             hit;
	logic             found_q;
	logic [IDX_W-1:0] idx_q;

	// Match the stored pair in either order
	assign hit = en && (((entry.lo == x) && (entry.hi == y)) ||
		((entry.lo == y) && (entry.hi == x)));

	// Track the match flag; entries arrive in rising order, so the latest hit wins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (clear) begin
			found_q <= 1'b0;
		end else if (hit) begin
			found_q <= 1'b1;
		end
	end

	// Hold the index of the latest hit
	always_ff @(posedge clk) begin
		if (hit) begin
			idx_q <= entry_idx;
		end
	end

	assign res.found = found_q;
	assign res.idx   = idx_q;

endmodule

@@ design/ted_merge.sv @@
`timescale 1ns / 1ps
module ted_merge
	import ted_pkg::*;
(
	input  lane_t [NUM_EDGES-1:0] lanes,
	input  logic  [CNT_W-1:0]     count,
	output merge_t                res
);

	logic [NEED_W-1:0] miss_ab;
	logic [NEED_W-1:0] miss_bc;
	logic [NEED_W-1:0] miss_ca;
	logic [NEED_W-1:0] off_bc;
	logic [NEED_W-1:0] off_ca;
	logic [CNT_W:0]    total;

	// Count the edges that have to be appended
	assign miss_ab = NEED_W'(!lanes[EDGE_AB].found);
	assign miss_bc = NEED_W'(!lanes[EDGE_BC].found);
	assign miss_ca = NEED_W'(!lanes[EDGE_CA].found);
	assign off_bc  = miss_ab;
	assign off_ca  = miss_ab + miss_bc;
	assign total   = (CNT_W + 1)'(count) + (CNT_W + 1)'(off_ca + miss_ca);

	always_comb begin
		res.need = off_ca + miss_ca;
		res.full = (total > (CNT_W + 1)'(MAX_EDGES));
		res.mask = {miss_ca[0], miss_bc[0], miss_ab[0]};
		// Found edges keep their stored index, new ones take the next free slots
		res.idx[EDGE_AB] = lanes[EDGE_AB].found ? lanes[EDGE_AB].idx : count[IDX_W-1:0];
		res.idx[EDGE_BC] = lanes[EDGE_BC].found ? lanes[EDGE_BC].idx :
			IDX_W'(count + CNT_W'(off_bc));
		res.idx[EDGE_CA] = lanes[EDGE_CA].found ? lanes[EDGE_CA].idx :
			IDX_W'(count + CNT_W'(off_ca));
	end

endmodule

@@ design/triangle_edge_dedup_table.sv @@
`timescale 1ns / 1ps
// Triangle edge de-duplication table.
// The face channel takes one triangle as three vertex indices. The res channel
// returns one item per face: the table index of edges ab, bc and ca, a mask of
// the edges newly appended, the face sequence number and a table-full flag.
// Three compare lanes, one per edge, share a single walk over the edge memory:
// one stored entry is read per cycle and checked by all lanes at once, then a
// merge stage counts missing edges, checks room and assigns new slots, and up
// to three new pairs are written in the append state, which a rejected face
// skips. The walk covers the entries in use before the face, so its length
// sets how long a face takes. The next face is taken the cycle after the
// result loads. One face is in work at a time; face.ready is high only while
// no face is in work.
// A face that does not fit leaves the table untouched and returns table_full
// with all other fields zero; its number is not consumed.
// Reset empties the table and zeroes the face counter; the memory itself is
// not cleared, as only written entries are ever read. If res stalls, the block
// accepts the next face and holds it back only at the end of its work.
module triangle_edge_dedup_table
	import ted_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	ted_face_if.sink   face,
	ted_res_if.source  res
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_MERGE  = 3'd2;
	localparam logic [2:0] ST_APPEND = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	logic [2:0]                 state_q;
	vert_t [NUM_EDGES-1:0]      vert_q;
	logic [CNT_W-1:0]           count_q;
	logic [CNT_W-1:0]           scan_q;
	logic [FACE_W-1:0]          faces_q;
	logic [1:0]                 app_q;
	merge_t                     merge_q;
	merge_t                     merge_c;
	lane_t [NUM_EDGES-1:0]      lanes;

	pair_t                      mem [MAX_EDGES];
	pair_t                      rd_data_s1;
	logic [IDX_W-1:0]           rd_idx_s1;
	logic                       rd_vld_s1;
	logic                       rd_en;
	logic                       wr_en;
	logic [IDX_W-1:0]           wr_addr;
	pair_t                      wr_data;

	logic                       accept;
	logic                       out_load;
	logic                       out_valid_q;
	logic [OUT_IDX_W-1:0]       out_ab_q;
	logic [OUT_IDX_W-1:0]       out_bc_q;
	logic [OUT_IDX_W-1:0]       out_ca_q;
	logic [MASK_W-1:0]          out_mask_q;
	logic [FACE_W-1:0]          out_face_q;
	logic                       out_full_q;

	assign face.ready = (state_q == ST_IDLE);
	assign accept     = face.valid && face.ready;
	assign rd_en      = (state_q == ST_SCAN) && (scan_q < count_q);
	assign out_load   = (state_q == ST_DONE) && (!out_valid_q || res.ready);

	// Pick the pair to append for the current edge slot
	always_comb begin
		wr_en   = (state_q == ST_APPEND) && merge_q.mask[app_q];
		wr_addr = merge_q.idx[app_q];
		case (app_q)
			2'd0:    wr_data = '{lo: vert_q[EDGE_AB], hi: vert_q[EDGE_BC]};
			2'd1:    wr_data = '{lo: vert_q[EDGE_BC], hi: vert_q[EDGE_CA]};
			2'd2:    wr_data = '{lo: vert_q[EDGE_CA], hi: vert_q[EDGE_AB]};
			default: wr_data = '{lo: vert_q[EDGE_AB], hi: vert_q[EDGE_BC]};
		endcase
	end

	// Edge memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[scan_q[IDX_W-1:0]];
			rd_idx_s1  <= scan_q[IDX_W-1:0];
		end
	end

	// Compare lanes, one per edge of the face
	ted_edge_lane u_lane_ab (
		.clk(clk), .arst_n(arst_n), .clear(accept), .en(rd_vld_s1),
		.entry_idx(rd_idx_s1), .entry(rd_data_s1),
		.x(vert_q[EDGE_AB]), .y(vert_q[EDGE_BC]), .res(lanes[EDGE_AB])
	);
	ted_edge_lane u_lane_bc (
		.clk(clk), .arst_n(arst_n), .clear(accept), .en(rd_vld_s1),
		.entry_idx(rd_idx_s1), .entry(rd_data_s1),
		.x(vert_q[EDGE_BC]), .y(vert_q[EDGE_CA]), .res(lanes[EDGE_BC])
	);
	ted_edge_lane u_lane_ca (
		.clk(clk), .arst_n(arst_n), .clear(accept), .en(rd_vld_s1),
		.entry_idx(rd_idx_s1), .entry(rd_data_s1),
		.x(vert_q[EDGE_CA]), .y(vert_q[EDGE_AB]), .res(lanes[EDGE_CA])
	);

	// Combine what the lanes found
	ted_merge u_merge (
		.lanes(lanes),
		.count(count_q),
		.res(merge_c)
	);

	// Latch the face vertices and the merge result
	always_ff @(posedge clk) begin
		if (accept) begin
			vert_q[EDGE_AB] <= face.vert_a;
			vert_q[EDGE_BC] <= face.vert_b;
			vert_q[EDGE_CA] <= face.vert_c;
		end
		if (state_q == ST_MERGE) begin
			merge_q <= merge_c;
		end
	end

	// Sequence one face: scan, merge, append (skipped for a face that does not fit), deliver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			scan_q    <= '0;
			faces_q   <= '0;
			app_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						scan_q  <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					rd_vld_s1 <= rd_en;
					if (rd_en) begin
						scan_q <= scan_q + CNT_W'(1);
					end else if (!rd_vld_s1) begin
						state_q <= ST_MERGE;
					end
				end
				ST_MERGE: begin
					app_q   <= '0;
					state_q <= merge_c.full ? ST_DONE : ST_APPEND;
				end
				ST_APPEND: begin
					if (app_q == 2'd2) begin
						count_q <= count_q + CNT_W'(merge_q.need);
						state_q <= ST_DONE;
					end else begin
						app_q <= app_q + 2'd1;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						if (!merge_q.full) begin
							faces_q <= faces_q + FACE_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (merge_q.full) begin
				out_ab_q   <= '0;
				out_bc_q   <= '0;
				out_ca_q   <= '0;
				out_mask_q <= '0;
				out_face_q <= '0;
				out_full_q <= 1'b1;
			end else begin
				out_ab_q   <= OUT_IDX_W'(merge_q.idx[EDGE_AB]);
				out_bc_q   <= OUT_IDX_W'(merge_q.idx[EDGE_BC]);
				out_ca_q   <= OUT_IDX_W'(merge_q.idx[EDGE_CA]);
				out_mask_q <= merge_q.mask;
				out_face_q <= faces_q;
				out_full_q <= 1'b0;
			end
		end
	end

	assign res.valid         = out_valid_q;
	assign res.edge_ab_index = out_ab_q;
	assign res.edge_bc_index = out_bc_q;
	assign res.edge_ca_index = out_ca_q;
	assign res.new_edge_mask = out_mask_q;
	assign res.face_number   = out_face_q;
	assign res.table_full    = out_full_q;

endmodule

@@ design/ted_checker.sv @@
`timescale 1ns / 1ps
module ted_checker
	import ted_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [OUT_IDX_W-1:0] ab_index,
	input logic [OUT_IDX_W-1:0] bc_index,
	input logic [OUT_IDX_W-1:0] ca_index,
	input logic [MASK_W-1:0]    mask,
	input logic [FACE_W-1:0]    face_num,
	input logic                 full
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({ab_index, bc_index,
		ca_index, mask, face_num, full}))
		else $error("result changed while stalled");

	// One face in work at a time
	a_one_face: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("face accepted while another is in work");

	// A rejected face reports zeros
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && full |-> ab_index == '0 && bc_index == '0 && ca_index == '0 &&
		mask == '0 && face_num == '0)
		else $error("rejected face carries nonzero fields");

	// Appended edges ab and bc take consecutive slots
	a_slot_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !full && mask[0] && mask[1] |->
		bc_index == ab_index + OUT_IDX_W'(1))
		else $error("appended edges not in consecutive slots");

endmodule

bind triangle_edge_dedup_table ted_checker u_ted_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(face.valid),
	.in_ready(face.ready),
	.out_valid(res.valid),
	.out_ready(res.ready),
	.ab_index(res.edge_ab_index),
	.bc_index(res.edge_bc_index),
	.ca_index(res.edge_ca_index),
	.mask(res.new_edge_mask),
	.face_num(res.face_number),
	.full(res.table_full)
);
